// ===== sv/pse_pkg.sv =====
package pse_pkg;

  localparam int unsigned DEFAULT_STACK_DEPTH = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DIV_STEPS = DATA_W;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DIV  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd3;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic signed [DATA_W-1:0] operand_value;
  } pse_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [COUNT_OUT_W-1:0]   stack_count;
    logic [STATUS_W-1:0]      status;
  } pse_out_t;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

// ===== sv/pse_stack.sv =====
module pse_stack
  import pse_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_STACK_DEPTH,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pse_alu.sv =====
module pse_alu
  import pse_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    A_IDLE,
    A_DIV,
    A_FIX,
    A_DONE
  } alu_state_e;

  alu_state_e        state_q, state_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [DATA_W-1:0] mag_l, mag_r;
  logic [DATA_W:0]   trial, diff;

  always_comb begin
    mag_l = req_i.left[DATA_W-1] ? (DATA_W'(0) - req_i.left) : req_i.left;
    mag_r = req_i.right[DATA_W-1] ? (DATA_W'(0) - req_i.right) : req_i.right;
    trial = {rem_q, quo_q[DATA_W-1]};
    diff  = trial - {1'b0, dvs_q};

    state_d = state_q;
    res_d   = res_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    step_d  = step_q;

    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            ALU_ADD: begin
              res_d   = req_i.left + req_i.right;
              state_d = A_DONE;
            end
            ALU_SUB: begin
              res_d   = req_i.left - req_i.right;
              state_d = A_DONE;
            end
            ALU_MUL: begin
              res_d   = DATA_W'(req_i.left * req_i.right);
              state_d = A_DONE;
            end
            default: begin
              quo_d   = mag_l;
              dvs_d   = mag_r;
              rem_d   = '0;
              neg_d   = req_i.left[DATA_W-1] ^ req_i.right[DATA_W-1];
              step_d  = STEP_W'(DIV_STEPS - 1);
              state_d = A_DIV;
            end
          endcase
        end
      end
      A_DIV: begin
        if (!diff[DATA_W]) begin
          rem_d = diff[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d = trial[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b0};
        end
        if (step_q == '0) begin
          state_d = A_FIX;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      A_FIX: begin
        res_d   = neg_q ? (DATA_W'(0) - quo_q) : quo_q;
        state_d = A_DONE;
      end
      A_DONE: begin
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done   = (state_q == A_DONE);
  assign rsp_o.result = res_q;

endmodule

// ===== sv/postfix_stack_evaluator_unit.sv =====
// Postfix integer evaluator on an operand stack.
// Input channel in_valid_i / in_ready_o carries one token per transaction:
// a push of a signed 32-bit value or an add, subtract, multiply or divide
// that pops right then left and pushes left op right.
// Output channel out_valid_o / out_ready_i returns one transaction per
// token: the new top of stack (zero when empty), the depth and a status
// (ok, underflow, stack full, divide by zero). Errors leave the stack as is.
// A token is taken only while the sequencer is idle. After acceptance, a
// push, an underflow or an unused opcode goes from decode to the output
// state; a divide by zero is caught in the read state; add, subtract,
// multiply and divide wait on the shared ALU, whose radix-2 divider takes
// one quotient bit per cycle. The next token is accepted the cycle after
// the result is loaded into the output register.
// Reset clears the depth, the sequencer and the output valid; the stack
// memory needs no clearing since only entries below the depth are read.
// If the receiver stalls, the result holds in the output register; a
// following token is still accepted and processed, then waits until the
// output register frees.
module postfix_stack_evaluator_unit
  import pse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pse_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pse_out_t out_data_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_ALU,
    S_OUT
  } seq_state_e;

  seq_state_e          state_q, state_d;
  logic [OPCODE_W-1:0] op_q, op_d;
  logic [DATA_W-1:0]   val_q, val_d;
  logic [CW-1:0]       count_q, count_d;
  logic [DATA_W-1:0]   top_q, top_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                out_valid_q, out_valid_d;
  pse_out_t            out_q, out_d;

  logic [CW-1:0]     rd_ptr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  pse_stack #(
    .DEPTH(STACK_DEPTH),
    .AW   (AW)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  pse_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign rd_ptr = count_q - CW'(2);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    count_d     = count_q;
    top_d       = top_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_ADD;
    alu_req.left  = rdata;
    alu_req.right = top_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i.opcode;
          val_d   = in_data_i.operand_value;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_q)
          OP_PUSH: begin
            if (count_q == CW'(STACK_DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              we       = 1'b1;
              waddr    = count_q[AW-1:0];
              wdata    = val_q;
              top_d    = val_q;
              count_d  = count_q + CW'(1);
              status_d = ST_OK;
            end
            state_d = S_OUT;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (count_q < CW'(2)) begin
              status_d = ST_UNDERFLOW;
              state_d  = S_OUT;
            end else begin
              raddr   = rd_ptr[AW-1:0];
              state_d = S_READ;
            end
          end
          default: begin
            status_d = ST_OK;
            state_d  = S_OUT;
          end
        endcase
      end
      S_READ: begin
        case (op_q)
          OP_ADD:  alu_req.op = ALU_ADD;
          OP_SUB:  alu_req.op = ALU_SUB;
          OP_MUL:  alu_req.op = ALU_MUL;
          default: alu_req.op = ALU_DIV;
        endcase
        if (op_q == OP_DIV && top_q == '0) begin
          status_d = ST_DIVZERO;
          state_d  = S_OUT;
        end else begin
          alu_req.start = 1'b1;
          state_d       = S_ALU;
        end
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          we       = 1'b1;
          waddr    = rd_ptr[AW-1:0];
          wdata    = alu_rsp.result;
          top_d    = alu_rsp.result;
          count_d  = count_q - CW'(1);
          status_d = ST_OK;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.top_value   = (count_q != '0) ? top_q : '0;
          out_d.stack_count = COUNT_OUT_W'(count_q);
          out_d.status      = status_q;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    top_q    <= top_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("token accepted while a token is in flight");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && out_data_o.status == ST_FULL |-> count_q == CW'(STACK_DEPTH))
    else $error("full status with free stack space");

  a_alu_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> state_q == S_ALU)
    else $error("alu result outside of alu wait");
`endif

endmodule
